// ----- hw/rtl/pse_pkg.sv -----
// Package for the PWM slot frame encoder: sizes, limits, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pse_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned PRE_W          = 4;
    localparam int unsigned HDR_W          = 5;
    localparam int unsigned CFG_DATA_W     = 5;
    localparam int unsigned CNT_W          = 5;
    localparam int unsigned BIT_IDX_W      = 3;
    localparam int unsigned PHASE_W        = 2;
    localparam int unsigned LEN_W          = 6;

    localparam logic [PRE_W-1:0] MAX_PREAMBLE_BITS = PRE_W'(12);
    localparam logic [HDR_W-1:0] MAX_HEADER_SLOTS  = HDR_W'(16);
    localparam logic [PRE_W-1:0] PRE_RESET         = PRE_W'(12);
    localparam logic [HDR_W-1:0] HDR_RESET         = HDR_W'(16);

    // A single-byte frame needs 2*pb + hs + 51 slots; it fits when
    // 2*pb + hs stays at or below 64 - 51.
    localparam logic [LEN_W-1:0] ONE_BYTE_BUDGET   = LEN_W'(64 - 51);

    // Configuration register indexes
    typedef enum logic {
        CFG_PREAMBLE_BITS = 1'b0,
        CFG_HEADER_SLOTS  = 1'b1
    } t_cfg_idx;

    // Slot phases within one encoded bit, and within the stop pattern
    localparam logic [PHASE_W-1:0] PH_LEAD = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] PH_MID  = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] PH_TAIL = PHASE_W'(2);

    // What kind of slot the datapath produces this cycle
    typedef enum logic [2:0] {
        K_NONE,
        K_PRE,
        K_HDR,
        K_DATA,
        K_CSUM,
        K_STOP
    } t_kind;

    typedef struct packed {
        logic  load;    // accept a request byte
        logic  emit;    // produce one slot of the given kind
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic in_frame;      // frame open; set when its first byte is taken
        logic cfg_pre_zero;  // configured preamble is empty
        logic cfg_hdr_zero;  // configured header gap is empty
        logic hdr_zero;      // latched header gap of this frame is empty
        logic fin;           // latched final mark, after the length check
        logic last;          // current slot is the last of its segment
        logic out_free;      // output register can take a slot
    } t_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/pse_req_if.sv -----
// Request channel: one byte of the frame plus its final mark.
// Depends on pse_pkg.
`default_nettype none

interface pse_req_if;
    import pse_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pse_slot_if.sv -----
// Slot channel: one line slot, toggle or hold, with the end-of-frame flag.
// No dependencies.
`default_nettype none

interface pse_slot_if;
    logic valid;
    logic ready;
    logic slot_toggle;
    logic frame_end;

    modport source (output valid, output slot_toggle, output frame_end, input ready);
    modport sink   (input valid, input slot_toggle, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pse_ctrl.sv -----
// Controller of the slot encoder: walks preamble, header, data, checksum
// and stop segments. Depends on pse_pkg.
`default_nettype none

module pse_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire pse_pkg::t_stat i_stat,
    output pse_pkg::t_cmd      o_cmd
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_HDR,
        S_DATA,
        S_CSUM,
        S_STOP
    } t_state;

    t_state r_state;
    t_state n_state;
    t_kind  kind;
    logic   step;

    // Map state to slot kind
    always_comb begin
        unique case (r_state)
            S_PRE:   kind = K_PRE;
            S_HDR:   kind = K_HDR;
            S_DATA:  kind = K_DATA;
            S_CSUM:  kind = K_CSUM;
            S_STOP:  kind = K_STOP;
            default: kind = K_NONE;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign step        = (r_state != S_IDLE) && i_stat.out_free;

    assign o_cmd.load = o_req_ready && i_req_valid;
    assign o_cmd.emit = step;
    assign o_cmd.kind = kind;

    // Leave idle on a request; on a segment's last slot, go to the next one or idle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    priority if (i_stat.in_frame)      n_state = S_DATA;
                    else if (!i_stat.cfg_pre_zero)     n_state = S_PRE;
                    else if (!i_stat.cfg_hdr_zero)     n_state = S_HDR;
                    else                               n_state = S_DATA;
                end
            end
            S_PRE: begin
                if (step && i_stat.last) begin
                    n_state = i_stat.hdr_zero ? S_DATA : S_HDR;
                end
            end
            S_HDR: begin
                if (step && i_stat.last) n_state = S_DATA;
            end
            S_DATA: begin
                if (step && i_stat.last) n_state = i_stat.fin ? S_CSUM : S_IDLE;
            end
            S_CSUM: begin
                if (step && i_stat.last) n_state = S_STOP;
            end
            S_STOP: begin
                if (step && i_stat.last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pse_dp.sv -----
// Datapath of the slot encoder: configuration, byte shifter, running XOR,
// segment counters and the output slot register. Depends on pse_pkg.
`default_nettype none

module pse_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_idx,
    input  wire logic [pse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [pse_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire logic                     i_final_byte,
    input  wire pse_pkg::t_cmd            i_cmd,
    output pse_pkg::t_stat                o_stat,
    output logic                          o_slot_valid,
    input  wire logic                     i_slot_ready,
    output logic                          o_slot_toggle,
    output logic                          o_frame_end
);
    import pse_pkg::*;

    logic [PRE_W-1:0]     r_cfg_pre;
    logic [HDR_W-1:0]     r_cfg_hdr;
    logic [BYTE_W-1:0]    r_sh;
    logic [BYTE_W-1:0]    r_xor;
    logic                 r_in_frame;
    logic                 r_fin;
    logic [HDR_W-1:0]     r_hs;
    logic [CNT_W-1:0]     r_cnt;
    logic [BIT_IDX_W-1:0] r_bit;
    logic [PHASE_W-1:0]   r_ph;
    logic                 r_ovalid;
    logic                 r_otoggle;
    logic                 r_oend;

    logic [PRE_W-1:0]     pb_sat;
    logic [HDR_W-1:0]     hs_sat;
    logic [LEN_W-1:0]     head_len;
    logic                 fin_eff;
    logic                 out_free;
    logic                 bit_last;
    logic                 last;
    logic                 slot_toggle;
    logic                 slot_end;

    // Clamp the registers to their bounds
    assign pb_sat   = (r_cfg_pre > MAX_PREAMBLE_BITS) ? MAX_PREAMBLE_BITS : r_cfg_pre;
    assign hs_sat   = (r_cfg_hdr > MAX_HEADER_SLOTS)  ? MAX_HEADER_SLOTS  : r_cfg_hdr;
    assign head_len = LEN_W'({pb_sat, 1'b0}) + LEN_W'(hs_sat);

    // Drop the final mark when a one-byte frame would overflow the slot budget
    assign fin_eff  = i_final_byte && (r_in_frame || (head_len <= ONE_BYTE_BUDGET));

    assign out_free = !r_ovalid || i_slot_ready;
    assign bit_last = (r_bit == BIT_IDX_W'(BYTE_W - 1)) && (r_ph == PH_TAIL);

    // Pick the slot value and the segment end for the current kind
    always_comb begin
        slot_toggle = 1'b0;
        slot_end    = 1'b0;
        last        = 1'b0;
        unique case (i_cmd.kind)
            K_PRE: begin
                slot_toggle = 1'b1;
                last        = (r_cnt == CNT_W'(1));
            end
            K_HDR: begin
                last        = (r_cnt == CNT_W'(1));
            end
            K_DATA, K_CSUM: begin
                unique case (r_ph)
                    PH_LEAD: slot_toggle = 1'b1;
                    PH_MID:  slot_toggle = r_sh[0];
                    PH_TAIL: slot_toggle = !r_sh[0];
                    default: slot_toggle = 1'b0;
                endcase
                last = bit_last;
            end
            K_STOP: begin
                slot_toggle = (r_ph != PH_MID);
                slot_end    = (r_ph == PH_TAIL);
                last        = (r_ph == PH_TAIL);
            end
            default: begin
                slot_toggle = 1'b0;
            end
        endcase
    end

    assign o_stat.in_frame     = r_in_frame;
    assign o_stat.cfg_pre_zero = (r_cfg_pre == '0);
    assign o_stat.cfg_hdr_zero = (r_cfg_hdr == '0);
    assign o_stat.hdr_zero     = (r_hs == '0);
    assign o_stat.fin          = r_fin;
    assign o_stat.last         = last;
    assign o_stat.out_free     = out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pre <= PRE_RESET;
            r_cfg_hdr <= HDR_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PREAMBLE_BITS: r_cfg_pre <= i_cfg_data[PRE_W-1:0];
                CFG_HEADER_SLOTS:  r_cfg_hdr <= i_cfg_data[HDR_W-1:0];
                default:           r_cfg_pre <= r_cfg_pre;
            endcase
        end
    end

    // Frame state: open flag, final mark and running XOR
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_xor      <= '0;
            r_fin      <= 1'b0;
        end else if (i_cmd.load) begin
            r_in_frame <= 1'b1;
            r_xor      <= (r_in_frame ? r_xor : '0) ^ i_data_byte;
            r_fin      <= fin_eff;
        end else if (i_cmd.emit && (i_cmd.kind == K_STOP) && last) begin
            r_in_frame <= 1'b0;
            r_xor      <= '0;
        end
    end

    // Segment counters, bit index and phase; with no preamble start on the header gap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_bit <= '0;
            r_ph  <= PH_LEAD;
        end else if (i_cmd.load) begin
            r_cnt <= (pb_sat == '0) ? CNT_W'(hs_sat) : CNT_W'({pb_sat, 1'b0});
            r_bit <= '0;
            r_ph  <= PH_LEAD;
        end else if (i_cmd.emit) begin
            unique case (i_cmd.kind)
                K_PRE:          r_cnt <= last ? CNT_W'(r_hs) : r_cnt - CNT_W'(1);
                K_HDR:          r_cnt <= r_cnt - CNT_W'(1);
                K_DATA, K_CSUM: begin
                    if (r_ph == PH_TAIL) begin
                        r_ph  <= PH_LEAD;
                        r_bit <= r_bit + BIT_IDX_W'(1);
                    end else begin
                        r_ph  <= r_ph + PHASE_W'(1);
                    end
                end
                K_STOP:         r_ph <= (r_ph == PH_TAIL) ? PH_LEAD : r_ph + PHASE_W'(1);
                default:        r_cnt <= r_cnt;
            endcase
        end
    end

    // Hold the byte being sent and the frame's header gap; switch to the checksum after the last bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sh <= i_data_byte;
            r_hs <= hs_sat;
        end else if (i_cmd.emit && ((i_cmd.kind == K_DATA) || (i_cmd.kind == K_CSUM))
                     && (r_ph == PH_TAIL)) begin
            r_sh <= bit_last ? r_xor : (r_sh >> 1);
        end
    end

    // Output slot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_slot_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_otoggle <= slot_toggle;
            r_oend    <= slot_end;
        end
    end

    assign o_slot_valid  = r_ovalid;
    assign o_slot_toggle = r_otoggle;
    assign o_frame_end   = r_oend;

endmodule

`default_nettype wire

// ----- hw/rtl/pwm_slot_frame_encoder.sv -----
// Top level of the PWM slot frame encoder: joins controller and datapath.
// Depends on pse_pkg, pse_req_if, pse_slot_if, pse_ctrl and pse_dp.
//
//   channel   dir  transaction          payload
//   i_req     in   one request byte     data_byte[7:0], final_byte
//   o_slot    out  one line slot        slot_toggle, frame_end
//   i_cfg_*   in   register write       i_cfg_idx selects, i_cfg_data[4:0]
//
// A byte is taken while the encoder is idle, then its slots leave one per
// cycle, while the slot channel does not stall, from a single output register:
// 24 slots for a byte inside a frame, up to 64 when the byte opens a frame
// (preamble, header, data) or closes it (checksum and stop). A stalled slot
// channel freezes the slot sequencer. Reset is synchronous, active low, and
// restores the preamble and header registers to 12 and 16.
`default_nettype none

module pwm_slot_frame_encoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [pse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pse_req_if.sink                          i_req,
    pse_slot_if.source                       o_slot
);
    import pse_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pse_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_req.data_byte),
        .i_final_byte  (i_req.final_byte),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_slot_valid  (o_slot.valid),
        .i_slot_ready  (o_slot.ready),
        .o_slot_toggle (o_slot.slot_toggle),
        .o_frame_end   (o_slot.frame_end)
    );

endmodule

`default_nettype wire
